@@ rtl/pst_pkg.sv @@
package pst_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int TIME_W    = 32;
    localparam int IDX_W     = 3;
    localparam int REQ_W     = 3;
    localparam int MASK_W    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK     = 3'd0,
        REQ_REGISTER = 3'd1,
        REQ_CLEAR    = 3'd2,
        REQ_SERVICE  = 3'd3,
        REQ_CHECK    = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  slot_index;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] past_time;
        logic [TIME_W-1:0] wait_time;
    } req_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ticks;
        logic [MASK_W-1:0] pending_mask;
        logic [MASK_W-1:0] serviced_mask;
        logic              any_serviced;
        logic              elapsed;
    } rsp_item_t;

    // Command token that travels down the row of slot cells
    typedef struct packed {
        logic              vld;
        req_code_t         req;
        logic              live;
        logic [IDX_W-1:0]  sel;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] interval;
    } token_t;

endpackage

@@ rtl/periodic_slot_timer_top.sv @@
// An accepted item is registered as a launch token that passes through the register
// of every slot cell in order before the result register captures it; the command
// token walks the row of slot cells one cell per cycle, and a new item is taken only
// once the previous result has been delivered.
// Reset: rst_n is asynchronous, active low; tick counter, every slot and the handshake
// state clear to zero.
module periodic_slot_timer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pst_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pst_pkg::rsp_item_t rsp_item
);
    import pst_pkg::*;

    // Handshake sequencer: idle, token in flight, result waiting
    state_t            state_reg, state_next;
    logic              launch;

    // Global tick counter, kept here and handed to the cells in the token
    logic [TIME_W-1:0] tick_count_reg, tick_count_next;

    // Check elapsed needs no slot state, so settle it at acceptance
    logic              elapsed_reg, elapsed_next;

    token_t            launch_tok_reg, launch_tok_next;
    token_t            chain [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] pend_vec;
    logic [NUM_SLOTS-1:0] serv_vec;
    logic [MASK_W-1:0] vis_pend;
    logic [MASK_W-1:0] vis_serv;
    rsp_item_t         rsp_reg, rsp_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (chain[NUM_SLOTS].vld)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        launch    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                launch    = req_valid;
            end
            ST_RUN:
            begin
            end
            ST_HOLD:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Accept: advance the counter on a tick, build the token, evaluate check elapsed
    always_comb
    begin
        tick_count_next = tick_count_reg;
        elapsed_next    = elapsed_reg;
        launch_tok_next = '0;
        if (launch)
        begin
            if (req_code_t'(req_item.req_type) == REQ_TICK)
            begin
                tick_count_next = tick_count_reg + TIME_W'(1);
            end
            elapsed_next = (req_code_t'(req_item.req_type) == REQ_CHECK) &&
                           ((tick_count_reg - req_item.past_time) > req_item.wait_time);
            launch_tok_next.vld      = 1'b1;
            launch_tok_next.req      = req_code_t'(req_item.req_type);
            launch_tok_next.live     = 1'b1;
            launch_tok_next.sel      = req_item.slot_index;
            launch_tok_next.now      = tick_count_next;
            launch_tok_next.interval = req_item.interval;
        end
    end

    assign chain[0] = launch_tok_reg;

    // Row of slot cells; each hands the token on to the next
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        pst_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1]),
            .pending (pend_vec[g]),
            .served  (serv_vec[g])
        );
    end

    // Only the first MASK_W slots show in the masks
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < NUM_SLOTS)
        begin : g_vis
            assign vis_pend[m] = pend_vec[m];
            assign vis_serv[m] = serv_vec[m];
        end
        else
        begin : g_off
            assign vis_pend[m] = 1'b0;
            assign vis_serv[m] = 1'b0;
        end
    end

    // Capture the result once the token leaves the last cell; every cell has settled by then
    always_comb
    begin
        rsp_next = rsp_reg;
        if (chain[NUM_SLOTS].vld)
        begin
            rsp_next.now_ticks     = tick_count_reg;
            rsp_next.pending_mask  = vis_pend;
            rsp_next.serviced_mask = vis_serv;
            rsp_next.any_serviced  = |serv_vec;
            rsp_next.elapsed       = elapsed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            elapsed_reg    <= 1'b0;
            launch_tok_reg <= '0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            elapsed_reg    <= elapsed_next;
            launch_tok_reg <= launch_tok_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign rsp_item = rsp_reg;

endmodule

@@ rtl/pst_cell.sv @@
module pst_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  pst_pkg::token_t tok_in,
    output pst_pkg::token_t tok_out,
    output logic            pending,
    output logic            served
);
    import pst_pkg::*;

    logic              active_reg, active_next;
    logic              pending_reg, pending_next;
    logic              served_reg, served_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0] last_run_reg, last_run_next;
    token_t            tok_reg, tok_next;
    logic              hit;
    logic [TIME_W-1:0] since_run;

    always_comb
    begin
        active_next   = active_reg;
        pending_next  = pending_reg;
        served_next   = served_reg;
        period_next   = period_reg;
        last_run_next = last_run_reg;
        since_run     = tok_in.now - last_run_reg;
        hit           = tok_in.vld && tok_in.live && (tok_in.sel == '0);
        tok_next      = tok_in;
        tok_next.sel  = tok_in.sel - IDX_W'(1);
        if (hit)
        begin
            tok_next.live = 1'b0;
        end
        if (tok_in.vld)
        begin
            served_next = 1'b0;
            unique case (tok_in.req)
                REQ_TICK:
                begin
                    if (active_reg && (since_run >= period_reg))
                    begin
                        pending_next = 1'b1;
                    end
                end
                REQ_REGISTER:
                begin
                    if (hit)
                    begin
                        active_next   = 1'b1;
                        period_next   = tok_in.interval;
                        last_run_next = tok_in.now;
                    end
                end
                REQ_CLEAR:
                begin
                    if (hit)
                    begin
                        active_next = 1'b0;
                        period_next = '0;
                    end
                end
                REQ_SERVICE:
                begin
                    if (active_reg && pending_reg)
                    begin
                        served_next   = 1'b1;
                        pending_next  = 1'b0;
                        last_run_next = tok_in.now;
                    end
                end
                default:
                begin
                    // check and unused codes leave the slot alone but for clearing its served flag
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            served_reg   <= 1'b0;
            period_reg   <= '0;
            last_run_reg <= '0;
            tok_reg      <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            pending_reg  <= pending_next;
            served_reg   <= served_next;
            period_reg   <= period_next;
            last_run_reg <= last_run_next;
            tok_reg      <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign pending = pending_reg;
    assign served  = served_reg;

endmodule

@@ rtl/pst_checker.sv @@
module pst_props (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  pst_pkg::rsp_item_t rsp_item
);
    import pst_pkg::*;

    // A waiting result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // One item in flight: no new item right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item taken while one is in flight");

    // A serviced slot leaves without its pending mark
    a_serv_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_item.serviced_mask & rsp_item.pending_mask) == '0))
        else $error("serviced slot still pending");

    // Service and check results never mix
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_item.elapsed && rsp_item.any_serviced) &&
                      ((rsp_item.serviced_mask == '0) || rsp_item.any_serviced))
        else $error("inconsistent result flags");

endmodule

bind periodic_slot_timer_top pst_props u_pst_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

@@ tb/sv/pst_checker.sv @@
module pst_checker
    import pst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req_item,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp_item,
    output int        fail_count,
    output int        awaited,
    output int        checked
);

    // Shadow copy of the timer state
    logic [TIME_W-1:0]    now_q;
    logic [NUM_SLOTS-1:0] active_q;
    logic [NUM_SLOTS-1:0] marked_q;
    logic [TIME_W-1:0]    period_q   [NUM_SLOTS];
    logic [TIME_W-1:0]    last_run_q [NUM_SLOTS];

    rsp_item_t due_reports[$];
    rsp_item_t want;

    task automatic report_fault(input string msg);
        $display("checker: %s", msg);
        fail_count++;
    endtask

    // Apply one request to the shadow state and return the report it should produce
    function automatic rsp_item_t apply_request(input req_item_t it);
        rsp_item_t            r;
        logic [NUM_SLOTS-1:0] served;
        logic [TIME_W-1:0]    span;
        int                   s;
        r      = '0;
        served = '0;
        case (it.req_type)
            REQ_TICK:
            begin
                now_q = now_q + 1'b1;
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    span = now_q - last_run_q[s];
                    if (active_q[s] && span >= period_q[s])
                        marked_q[s] = 1'b1;
                end
            end
            REQ_REGISTER:
            begin
                if (int'(it.slot_index) < NUM_SLOTS)
                begin
                    active_q[it.slot_index]   = 1'b1;
                    last_run_q[it.slot_index] = now_q;
                    period_q[it.slot_index]   = it.interval;
                end
            end
            REQ_CLEAR:
            begin
                if (int'(it.slot_index) < NUM_SLOTS)
                begin
                    active_q[it.slot_index] = 1'b0;
                    period_q[it.slot_index] = '0;
                end
            end
            REQ_SERVICE:
            begin
                for (s = 0; s < NUM_SLOTS; s++)
                begin
                    if (active_q[s] && marked_q[s])
                    begin
                        last_run_q[s] = now_q;
                        marked_q[s]   = 1'b0;
                        served[s]     = 1'b1;
                    end
                end
            end
            REQ_CHECK:
            begin
                span      = now_q - it.past_time;
                r.elapsed = (span > it.wait_time);
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase
        r.now_ticks = now_q;
        for (s = 0; s < NUM_SLOTS && s < MASK_W; s++)
        begin
            r.pending_mask[s]  = marked_q[s];
            r.serviced_mask[s] = served[s];
        end
        r.any_serviced = |served;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_q    = '0;
            active_q = '0;
            marked_q = '0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                period_q[s]   = '0;
                last_run_q[s] = '0;
            end
            due_reports.delete();
            fail_count = 0;
            checked    = 0;
            awaited   <= 0;
        end
        else
        begin
            // compare first, so a result can never match an item taken at the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (due_reports.size() == 0)
                    report_fault($sformatf("result %0d arrived with no item outstanding",
                                           checked));
                else
                begin
                    want = due_reports.pop_front();
                    if (rsp_item.now_ticks !== want.now_ticks)
                        report_fault($sformatf("result %0d now_ticks %h, expected %h",
                                               checked, rsp_item.now_ticks, want.now_ticks));
                    if (rsp_item.pending_mask !== want.pending_mask)
                        report_fault($sformatf("result %0d pending_mask %h, expected %h",
                                               checked, rsp_item.pending_mask,
                                               want.pending_mask));
                    if (rsp_item.serviced_mask !== want.serviced_mask)
                        report_fault($sformatf("result %0d serviced_mask %h, expected %h",
                                               checked, rsp_item.serviced_mask,
                                               want.serviced_mask));
                    if (rsp_item.any_serviced !== want.any_serviced)
                        report_fault($sformatf("result %0d any_serviced %b, expected %b",
                                               checked, rsp_item.any_serviced,
                                               want.any_serviced));
                    if (rsp_item.elapsed !== want.elapsed)
                        report_fault($sformatf("result %0d elapsed %b, expected %b",
                                               checked, rsp_item.elapsed, want.elapsed));
                end
                checked++;
            end
            if (req_valid && !req_stall)
                due_reports.push_back(apply_request(req_item));
            awaited <= due_reports.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    import pst_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    req_item_t req_item  = '0;
    logic      rsp_stall = 1'b0;
    logic      req_stall;
    logic      rsp_valid;
    rsp_item_t rsp_item;

    int fail_count;
    int awaited;
    int checked;

    // Flow-control knobs, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // Tick count as the sender sees it, so check items can aim near the present time
    logic [TIME_W-1:0] now_est = '0;
    int                accepted = 0;

    // Idling pattern of each random phase: none, sender only, receiver only, both
    int phase_idle  [4] = '{0, 69, 0, 20};
    int phase_stall [4] = '{0, 0, 69, 20};

    always #5 clk = ~clk;

    periodic_slot_timer_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    pst_checker check_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .fail_count (fail_count),
        .awaited    (awaited),
        .checked    (checked)
    );

    // Receiver back-pressure: draw a fresh stall decision on every edge
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one item: idle a random number of cycles first, then hold the item
    // steady until the block takes it. Valid is only dropped during a gap, so
    // back-to-back items keep it high without a glitch.
    task automatic issue_request(input logic [REQ_W-1:0]  code,
                                 input logic [IDX_W-1:0]  slot,
                                 input logic [TIME_W-1:0] period,
                                 input logic [TIME_W-1:0] past,
                                 input logic [TIME_W-1:0] hold);
        req_item_t it;
        it.req_type   = code;
        it.slot_index = slot;
        it.interval   = period;
        it.past_time  = past;
        it.wait_time  = hold;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        if (code == REQ_TICK)
            now_est = now_est + 1'b1;
        accepted++;
    endtask

    // Stop offering items and hold until every outstanding result has come back.
    // Advance to the next edge before looking, so an item taken at the last edge is counted.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited != 0);
    endtask

    initial
    begin
        int                pick;
        logic [REQ_W-1:0]  code;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] past;
        logic [TIME_W-1:0] hold;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side
        issue_request(REQ_TICK, 3'd0, '0, '0, '0);
        // zero period: slot 0 is marked on every tick
        issue_request(REQ_REGISTER, 3'd0, 32'h0000_0000, '0, '0);
        issue_request(REQ_TICK, 3'd5, '1, '1, '1);
        // longest period on the top slot: never due within this run
        issue_request(REQ_REGISTER, 3'd7, 32'hFFFF_FFFF, '0, '0);
        issue_request(REQ_REGISTER, 3'd3, 32'd2, '0, '0);
        issue_request(REQ_TICK, 3'd0, '0, '0, '0);
        issue_request(REQ_TICK, 3'd0, '0, '0, '0);
        // clear keeps the pending mark on slot 3, so the service skips it
        issue_request(REQ_CLEAR, 3'd3, '1, '0, '0);
        issue_request(REQ_SERVICE, 3'd0, '0, '0, '0);
        // register keeps the mark too, so slot 3 is now served at once
        issue_request(REQ_REGISTER, 3'd3, 32'd5, '0, '0);
        issue_request(REQ_SERVICE, 3'd7, '1, '1, '1);
        issue_request(REQ_SERVICE, 3'd0, '0, '0, '0);
        // elapsed: extremes, exact equality and a past time just ahead of now (wrap)
        issue_request(REQ_CHECK, 3'd0, '0, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_CHECK, 3'd0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(REQ_CHECK, 3'd0, '0, now_est + 1'b1, 32'hFFFF_FFFE);
        issue_request(REQ_CHECK, 3'd0, '0, now_est, 32'h0000_0000);
        issue_request(REQ_CHECK, 3'd0, '0, now_est - 1'b1, 32'h0000_0000);
        // unused codes change nothing
        issue_request(3'd5, 3'd7, '1, '1, '1);
        issue_request(3'd6, 3'd0, '1, '1, '1);
        issue_request(3'd7, 3'd3, '0, '0, '0);
        issue_request(REQ_CLEAR, 3'd7, '0, '0, '0);
        issue_request(REQ_CLEAR, 3'd0, '0, '0, '0);
        issue_request(REQ_TICK, 3'd0, '0, '0, '0);
        issue_request(REQ_SERVICE, 3'd0, '0, '0, '0);
        drain_results();

        // Random part: mostly short periods so slots fall due, then ticks and
        // services to work the marks; fields an item does not use carry noise.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int n = 0; n < 163; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 38)
                    code = REQ_TICK;
                else if (pick < 52)
                    code = REQ_REGISTER;
                else if (pick < 58)
                    code = REQ_CLEAR;
                else if (pick < 76)
                    code = REQ_SERVICE;
                else if (pick < 92)
                    code = REQ_CHECK;
                else
                    code = 3'($urandom_range(7, 5));
                pick = $urandom_range(9);
                if (pick < 7)
                    period = $urandom_range(12);
                else
                    period = $urandom;
                if ($urandom_range(9) < 6)
                    past = now_est - $urandom_range(30);
                else
                    past = $urandom;
                if ($urandom_range(9) < 6)
                    hold = $urandom_range(30);
                else
                    hold = $urandom;
                issue_request(code, 3'($urandom_range(7)), period, past, hold);
            end
            // hold the sender until the block has caught up before the next pattern
            drain_results();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (20) @(posedge clk);

        $display("summary: %0d items accepted, %0d results checked, %0d mismatches",
                 accepted, checked, fail_count);
        $display("summary: directed slot cases, then random traffic under four idle patterns");
        if (fail_count == 0 && awaited == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog: give up well past the slowest correct run
    initial
    begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
